// ===== sv/tpt_pkg.sv =====
// shared types and constants of the page table translator
// used by tpt_front, tpt_back, the top level and the checker
`timescale 1ns / 1ps
`default_nettype none
package tpt_pkg;
  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned OFFSET_W = 8;
  localparam int unsigned PAGE_W   = 8;
  localparam int unsigned FRAME_W  = 7;
  localparam int unsigned TLB_N    = 16;
  localparam int unsigned TLB_IW   = $clog2(TLB_N);
  localparam int unsigned PA_W     = FRAME_W + OFFSET_W;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned PAGES    = 1 << PAGE_W;
  localparam int unsigned FRAMES   = 1 << FRAME_W;

  typedef struct packed {
    logic [PAGE_W-1:0]   page;
    logic [OFFSET_W-1:0] offset;
  } item_t;

  typedef enum logic {
    ST_LOOKUP,
    ST_TABLE
  } back_state_e;
endpackage
`default_nettype wire

// ===== sv/tpt_front.sv =====
// front end: two-entry input queue that splits an address into page and offset
// depends on tpt_pkg
`timescale 1ns / 1ps
`default_nettype none
module tpt_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push_i,
  input  wire logic [tpt_pkg::ADDR_W-1:0]   logical_address_i,
  output logic                              full_o,
  output logic                              head_valid_o,
  output tpt_pkg::item_t                    head_o,
  input  wire logic                         head_pop_i
);
  tpt_pkg::item_t ent_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           do_push, do_pop;

  assign full_o       = (cnt_q == 2'd2);
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = ent_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = head_pop_i && head_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      if (do_push && !do_pop) cnt_q <= cnt_q + 2'd1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_ptr_q].page <=
        logical_address_i[tpt_pkg::OFFSET_W +: tpt_pkg::PAGE_W];
      ent_q[wr_ptr_q].offset <= logical_address_i[tpt_pkg::OFFSET_W-1:0];
    end
  end
endmodule
`default_nettype wire

// ===== sv/tpt_back.sv =====
// back end: tlb, page table, fifo frame allocation, counters and result register
// depends on tpt_pkg
`timescale 1ns / 1ps
`default_nettype none
module tpt_back (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         head_valid_i,
  input  wire tpt_pkg::item_t               head_i,
  output logic                              head_pop_o,
  output logic                              empty_o,
  input  wire logic                         pop_i,
  output logic [tpt_pkg::PA_W-1:0]          physical_address_o,
  output logic                              tlb_hit_o,
  output logic                              page_fault_o,
  output logic [tpt_pkg::CNT_W-1:0]         access_count_o,
  output logic [tpt_pkg::CNT_W-1:0]         miss_count_o,
  output logic [tpt_pkg::CNT_W-1:0]         fault_count_o
);
  tpt_pkg::back_state_e state_q, state_d;

  logic [tpt_pkg::TLB_N-1:0]   tlb_valid_q;
  logic [tpt_pkg::PAGE_W-1:0]  tlb_page_q  [tpt_pkg::TLB_N];
  logic [tpt_pkg::FRAME_W-1:0] tlb_frame_q [tpt_pkg::TLB_N];
  logic [tpt_pkg::TLB_IW-1:0]  fill_q;
  logic [tpt_pkg::PAGES-1:0]   resident_q, resident_d;
  logic [tpt_pkg::FRAME_W-1:0] fptr_q;
  logic                        all_used_q;
  logic [tpt_pkg::CNT_W-1:0]   acc_q, miss_q, fault_q;
  logic                        out_valid_q;
  logic [tpt_pkg::PA_W-1:0]    pa_q;
  logic                        hit_q, pf_q;

  // page table and reverse map, read data registered
  logic [tpt_pkg::FRAME_W-1:0] pmap_mem  [tpt_pkg::PAGES];
  logic [tpt_pkg::PAGE_W-1:0]  owner_mem [tpt_pkg::FRAMES];
  logic [tpt_pkg::FRAME_W-1:0] pmap_rd_q;
  logic [tpt_pkg::PAGE_W-1:0]  owner_rd_q;

  logic                        hit;
  logic [tpt_pkg::FRAME_W-1:0] hit_frame;
  logic                        finish_hit, finish_miss, fault;
  logic [tpt_pkg::FRAME_W-1:0] miss_frame;

  always_comb begin
    hit       = 1'b0;
    hit_frame = '0;
    for (int i = tpt_pkg::TLB_N - 1; i >= 0; i--) begin
      if (tlb_valid_q[i] && tlb_page_q[i] == head_i.page) begin
        hit       = 1'b1;
        hit_frame = tlb_frame_q[i];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      tpt_pkg::ST_LOOKUP: begin
        if (head_valid_i && !out_valid_q && !hit) state_d = tpt_pkg::ST_TABLE;
      end
      tpt_pkg::ST_TABLE: state_d = tpt_pkg::ST_LOOKUP;
      default:           state_d = tpt_pkg::ST_LOOKUP;
    endcase
  end

  always_comb begin
    finish_hit  = 1'b0;
    finish_miss = 1'b0;
    case (state_q)
      tpt_pkg::ST_LOOKUP: finish_hit  = head_valid_i && !out_valid_q && hit;
      tpt_pkg::ST_TABLE:  finish_miss = 1'b1;
      default: begin
        finish_hit  = 1'b0;
        finish_miss = 1'b0;
      end
    endcase
    fault      = finish_miss && !resident_q[head_i.page];
    miss_frame = fault ? fptr_q : pmap_rd_q;
    head_pop_o = finish_hit || finish_miss;
  end

  // residency: a fault on a reused frame drops the old owner, then maps the new page
  always_comb begin
    resident_d = resident_q;
    if (fault) begin
      if (all_used_q) resident_d[owner_rd_q] = 1'b0;
      resident_d[head_i.page] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tpt_pkg::ST_LOOKUP;
      tlb_valid_q <= '0;
      fill_q      <= '0;
      resident_q  <= '0;
      fptr_q      <= '0;
      all_used_q  <= 1'b0;
      acc_q       <= '0;
      miss_q      <= '0;
      fault_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      resident_q  <= resident_d;
      out_valid_q <= head_pop_o || (out_valid_q && !pop_i);
      if (head_pop_o) begin
        acc_q <= acc_q + 1'b1;
      end
      if (finish_miss) begin
        miss_q              <= miss_q + 1'b1;
        tlb_valid_q[fill_q] <= 1'b1;
        fill_q              <= fill_q + 1'b1;
      end
      if (fault) begin
        fault_q <= fault_q + 1'b1;
        fptr_q  <= fptr_q + 1'b1;
        if (fptr_q == '1) all_used_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish_miss) begin
      tlb_page_q[fill_q]  <= head_i.page;
      tlb_frame_q[fill_q] <= miss_frame;
    end
    if (head_pop_o) begin
      pa_q  <= {(finish_hit ? hit_frame : miss_frame), head_i.offset};
      hit_q <= finish_hit;
      pf_q  <= fault;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fault) begin
      pmap_mem[head_i.page] <= fptr_q;
      owner_mem[fptr_q]     <= head_i.page;
    end
    pmap_rd_q  <= pmap_mem[head_i.page];
    owner_rd_q <= owner_mem[fptr_q];
  end

  assign empty_o            = !out_valid_q;
  assign physical_address_o = pa_q;
  assign tlb_hit_o          = hit_q;
  assign page_fault_o       = pf_q;
  assign access_count_o     = acc_q;
  assign miss_count_o       = miss_q;
  assign fault_count_o      = fault_q;
endmodule
`default_nettype wire

// ===== sv/tlb_page_table_translator.sv =====
// top level of the page table translator: input queue front and translation back
// depends on tpt_pkg, tpt_front and tpt_back
//
//   channel   handshake        payload
//   request   push_i / full_o  logical_address_i
//   result    pop_i / empty_o  physical_address_o, tlb_hit_o, page_fault_o, counters
//
// a tlb hit finishes in the lookup state of the back end, a miss in the table state (page table memory read)
// a transaction pushed into an empty queue reaches the back end from the queue registers, in the cycle after the push
// the result register holds one result; the back end waits while it is full
// even with results popped at once, a new request waits until the last result has left the result register
// the input queue holds two requests, so pushes go on while a result waits
// reset clears the queue, tlb valid bits, residency bits, pointers and counters
`timescale 1ns / 1ps
`default_nettype none
module tlb_page_table_translator (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push_i,
  output logic                              full_o,
  input  wire logic [tpt_pkg::ADDR_W-1:0]   logical_address_i,
  output logic                              empty_o,
  input  wire logic                         pop_i,
  output logic [tpt_pkg::PA_W-1:0]          physical_address_o,
  output logic                              tlb_hit_o,
  output logic                              page_fault_o,
  output logic [tpt_pkg::CNT_W-1:0]         access_count_o,
  output logic [tpt_pkg::CNT_W-1:0]         miss_count_o,
  output logic [tpt_pkg::CNT_W-1:0]         fault_count_o
);
  // queued request between front and back
  logic           head_valid;
  tpt_pkg::item_t head;
  logic           head_pop;

  // front: accepts requests and splits page and offset
  tpt_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push_i            (push_i),
    .logical_address_i (logical_address_i),
    .full_o            (full_o),
    .head_valid_o      (head_valid),
    .head_o            (head),
    .head_pop_i        (head_pop)
  );

  // back: lookup, page table walk, frame allocation, result register
  tpt_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .head_valid_i       (head_valid),
    .head_i             (head),
    .head_pop_o         (head_pop),
    .empty_o            (empty_o),
    .pop_i              (pop_i),
    .physical_address_o (physical_address_o),
    .tlb_hit_o          (tlb_hit_o),
    .page_fault_o       (page_fault_o),
    .access_count_o     (access_count_o),
    .miss_count_o       (miss_count_o),
    .fault_count_o      (fault_count_o)
  );
endmodule
`default_nettype wire

// ===== sv/tpt_checker.sv =====
// port checker for the page table translator, bound to the top level
// depends on tpt_pkg
`timescale 1ns / 1ps
`default_nettype none
module tpt_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       empty_o,
  input wire logic                       pop_i,
  input wire logic [tpt_pkg::PA_W-1:0]   physical_address_o,
  input wire logic                       tlb_hit_o,
  input wire logic                       page_fault_o,
  input wire logic [tpt_pkg::CNT_W-1:0]  access_count_o,
  input wire logic [tpt_pkg::CNT_W-1:0]  miss_count_o,
  input wire logic [tpt_pkg::CNT_W-1:0]  fault_count_o
);
  // a fault only follows a miss
  a_hit_no_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && tlb_hit_o) |-> !page_fault_o) else $error("fault on tlb hit");

  // every fault counts as a miss, every miss as an access
  a_count_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> (fault_count_o <= miss_count_o) && (miss_count_o <= access_count_o))
    else $error("counter order broken");

  // a fault result is always counted as a miss
  a_fault_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && page_fault_o) |-> (fault_count_o != 0) && (miss_count_o != 0))
    else $error("fault not counted");

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(physical_address_o)))
    else $error("waiting result changed");
endmodule

bind tlb_page_table_translator tpt_checker u_tpt_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .empty_o            (empty_o),
  .pop_i              (pop_i),
  .physical_address_o (physical_address_o),
  .tlb_hit_o          (tlb_hit_o),
  .page_fault_o       (page_fault_o),
  .access_count_o     (access_count_o),
  .miss_count_o       (miss_count_o),
  .fault_count_o      (fault_count_o)
);
`default_nettype wire
